// ===== src/fsc_pkg.sv =====
// Shared types and constants for the framebuffer scanout converter.
package fsc_pkg;

   localparam int BASE_W = 22;
   localparam int DEST_W = 19;
   localparam int ADDR_W = 24;
   localparam int COLOR_W = 32;
   localparam int OFFSET_W = 32;
   localparam int PIXEL_W = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [OFFSET_W-1:0] OFFSET_LIMIT = 32'h0030_0000;
   localparam logic [ADDR_W-1:0] RAM_BASE = 24'h80_0000;
   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   // Action codes of an input item.
   localparam logic ACT_FRAME = 1'b0;
   localparam logic ACT_PIXEL = 1'b1;

   // Kind codes of a result item.
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Register index, taken from address bit 2.
   localparam logic CSR_FLIP = 1'b0;
   localparam logic CSR_MODE = 1'b1;

   typedef struct packed {
      logic wide_hit;
      logic [BASE_W-1:0] base;
   } frame_info_type;

endpackage

// ===== src/fsc_frame_calc.sv =====
// Frame-start offset decode: wide-pitch detection and base clamping.
module fsc_frame_calc
   import fsc_pkg::*;
(
   input  logic [OFFSET_W-1:0] fb_offset,
   output frame_info_type      info
);

   logic [5:0] nibble_sum;
   logic       div15;

   // 0x78000 is 15 << 15. Since 16 is 1 modulo 15, the upper 17 bits are
   // a multiple of 15 exactly when the sum of their nibbles is.
   always_comb begin
      nibble_sum = 6'(fb_offset[18:15]) + 6'(fb_offset[22:19]) + 6'(fb_offset[26:23])
                 + 6'(fb_offset[30:27]) + 6'(fb_offset[31]);
      div15 = (nibble_sum == 6'd0) || (nibble_sum == 6'd15) || (nibble_sum == 6'd30)
           || (nibble_sum == 6'd45) || (nibble_sum == 6'd60);
      info.wide_hit = (fb_offset != '0) && (fb_offset[14:0] == 15'd0) && div15;
      info.base = (fb_offset > OFFSET_LIMIT) ? '0 : fb_offset[BASE_W-1:0];
   end

endmodule

// ===== src/fsc_pixel_calc.sv =====
// Pixel result datapath: colour conversion, source address and destination index.
module fsc_pixel_calc
   import fsc_pkg::*;
#(
   parameter int SRC_WIDTH = 640,
   parameter int SRC_HEIGHT = 240,
   parameter int COL_W = 10,
   parameter int ROW_W = 8
)
(
   input  logic [PIXEL_W-1:0] pixel,
   input  logic [COL_W-1:0]   col,
   input  logic [ROW_W-1:0]   row,
   input  logic [BASE_W-1:0]  base,
   input  logic               wide_pitch,
   input  logic               flip,
   input  logic               sixteen_bit,
   input  logic               second_row,
   output logic [COLOR_W-1:0] color,
   output logic [DEST_W-1:0]  dest_index,
   output logic [ADDR_W-1:0]  source_address
);

   logic [4:0]       r5, g5, b5;
   logic [ROW_W-1:0] src_row;
   logic [20:0]      dest_full;
   logic [ADDR_W-1:0] row_offset;

   always_comb begin
      r5 = pixel[14:10];
      g5 = pixel[9:5];
      b5 = pixel[4:0];
      if (sixteen_bit) begin
         color = {17'd0, pixel[14:0]};
      end else begin
         color = {ALPHA_OPAQUE, r5, r5[4:2], g5, g5[4:2], b5, b5[4:2]};
      end

      src_row = flip ? ROW_W'(SRC_HEIGHT - 1) - row : row;
      dest_full = 21'({src_row, second_row}) * 21'(SRC_WIDTH) + 21'(col);
      dest_index = dest_full[DEST_W-1:0];

      // Rows are 2048 bytes apart when wide, else 1280 = 1024 + 256.
      if (wide_pitch) begin
         row_offset = ADDR_W'(row) << 11;
      end else begin
         row_offset = (ADDR_W'(row) << 10) + (ADDR_W'(row) << 8);
      end
      source_address = RAM_BASE + ADDR_W'(base) + row_offset + (ADDR_W'(col) << 1);
   end

endmodule

// ===== src/framebuffer_scanout_converter.sv =====
// Top level of the framebuffer scanout converter with its register port.
// Items pass through the input register, then the result register, to the outputs.
// Throughput: a frame-start item each cycle unless the result side stalls; a pixel
// item is held while the single result register gives two destination writes in turn.
// Reset (synchronous): clears the pitch latch, base and position counters and
// sets flip_ff to 1 and mode_ff to 0.
module framebuffer_scanout_converter
   import fsc_pkg::*;
#(
   parameter int SRC_WIDTH = 640,
   parameter int SRC_HEIGHT = 240
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_action,
   input  logic [OFFSET_W-1:0]   req_fb_offset,
   input  logic [PIXEL_W-1:0]    req_pixel,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_kind,
   output logic [DEST_W-1:0]     rsp_dest_index,
   output logic [COLOR_W-1:0]    rsp_color,
   output logic [ADDR_W-1:0]     rsp_source_address,
   output logic                  rsp_wide_pitch,
   output logic                  rsp_last,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
   localparam int ROW_W = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;

   // Configuration registers.
   logic flip_ff, flip_in;
   logic mode_ff, mode_in;
   logic csr_write;

   // Input register.
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_action_ff;
   logic [OFFSET_W-1:0] s1_offset_ff;
   logic [PIXEL_W-1:0]  s1_pixel_ff;
   logic                phase_ff, phase_in;

   // Frame state.
   logic              pitch_ff, pitch_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff;
   logic [DEST_W-1:0]  rsp_dest_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic               rsp_wide_ff;
   logic               rsp_last_ff;

   logic out_load, s1_done, req_take;
   frame_info_type frame_info;
   logic [COLOR_W-1:0] px_color;
   logic [DEST_W-1:0]  px_dest;
   logic [ADDR_W-1:0]  px_addr;

   fsc_frame_calc u_frame (
      .fb_offset (s1_offset_ff),
      .info      (frame_info)
   );

   fsc_pixel_calc #(
      .SRC_WIDTH  (SRC_WIDTH),
      .SRC_HEIGHT (SRC_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_pixel (
      .pixel          (s1_pixel_ff),
      .col            (col_ff),
      .row            (row_ff),
      .base           (base_ff),
      .wide_pitch     (pitch_ff),
      .flip           (flip_ff),
      .sixteen_bit    (mode_ff),
      .second_row     (phase_ff),
      .color          (px_color),
      .dest_index     (px_dest),
      .source_address (px_addr)
   );

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_MODE) ? CSR_DATA_W'(mode_ff) : CSR_DATA_W'(flip_ff);

   // A pixel item holds the input register for two results, a frame item for one.
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign s1_done = s1_valid_ff && out_load && (s1_action_ff == ACT_FRAME || phase_ff);
   assign req_stall = s1_valid_ff && !s1_done;
   assign req_take = req_valid && !req_stall;

   always_comb begin
      flip_in = flip_ff;
      mode_in = mode_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_FLIP: flip_in = csr_pwdata[0];
            CSR_MODE: mode_in = csr_pwdata[0];
            default: ;
         endcase
      end

      s1_valid_in = req_take ? 1'b1 : (s1_done ? 1'b0 : s1_valid_ff);
      phase_in = phase_ff;
      if (s1_valid_ff && out_load && s1_action_ff == ACT_PIXEL) begin
         phase_in = !phase_ff;
      end

      pitch_in = pitch_ff;
      base_in = base_ff;
      col_in = col_ff;
      row_in = row_ff;
      if (s1_done) begin
         if (s1_action_ff == ACT_FRAME) begin
            pitch_in = pitch_ff | frame_info.wide_hit;
            base_in = frame_info.base;
            col_in = '0;
            row_in = '0;
         end else if (col_ff == COL_W'(SRC_WIDTH - 1)) begin
            col_in = '0;
            row_in = (row_ff == ROW_W'(SRC_HEIGHT - 1)) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b1;
         mode_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
         pitch_ff <= 1'b0;
         base_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flip_ff <= flip_in;
         mode_ff <= mode_in;
         s1_valid_ff <= s1_valid_in;
         phase_ff <= phase_in;
         pitch_ff <= pitch_in;
         base_ff <= base_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_action;
         s1_offset_ff <= req_fb_offset;
         s1_pixel_ff <= req_pixel;
      end
      if (out_load && s1_valid_ff) begin
         if (s1_action_ff == ACT_FRAME) begin
            rsp_kind_ff <= KIND_FRAME;
            rsp_dest_ff <= '0;
            rsp_color_ff <= '0;
            rsp_addr_ff <= RAM_BASE + ADDR_W'(frame_info.base);
            rsp_wide_ff <= pitch_ff | frame_info.wide_hit;
            rsp_last_ff <= 1'b1;
         end else begin
            rsp_kind_ff <= KIND_PIXEL;
            rsp_dest_ff <= px_dest;
            rsp_color_ff <= px_color;
            rsp_addr_ff <= px_addr;
            rsp_wide_ff <= pitch_ff;
            rsp_last_ff <= phase_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_dest_index = rsp_dest_ff;
   assign rsp_color = rsp_color_ff;
   assign rsp_source_address = rsp_addr_ff;
   assign rsp_wide_pitch = rsp_wide_ff;
   assign rsp_last = rsp_last_ff;

   // A frame acknowledge is always the only result of its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_FRAME |-> rsp_last_ff)
      else $error("frame acknowledge without last");

   // The wide-pitch latch is sticky until reset.
   assert property (@(posedge clock) disable iff (reset)
      pitch_ff |=> pitch_ff)
      else $error("pitch latch cleared without reset");

   // The second destination row is only pending for a held pixel item.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> s1_valid_ff && s1_action_ff == ACT_PIXEL)
      else $error("second row pending without a pixel item");

   // The column counter stays inside the source width.
   assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_W'(SRC_WIDTH - 1))
      else $error("column counter out of range");

endmodule

// ===== bench/framebuffer_scanout_checker.sv =====
// Checker for the scanout converter: predicts destination writes and compares them.
module framebuffer_scanout_checker
   import fsc_pkg::*;
#(
   parameter int SRC_WIDTH = 640,
   parameter int SRC_HEIGHT = 240
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_action,
   input  logic [OFFSET_W-1:0]   req_fb_offset,
   input  logic [PIXEL_W-1:0]    req_pixel,

   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_kind,
   input  logic [DEST_W-1:0]     rsp_dest_index,
   input  logic [COLOR_W-1:0]    rsp_color,
   input  logic [ADDR_W-1:0]     rsp_source_address,
   input  logic                  rsp_wide_pitch,
   input  logic                  rsp_last,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic [CSR_DATA_W-1:0] csr_prdata,
   input  logic                  csr_pready,

   output int                    mismatches,
   output int                    writes_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OFFSET_W-1:0] WIDE_STRIDE = 32'h0007_8000;
   localparam int WIDE_PITCH = 2048;
   localparam int NARROW_PITCH = 1280;
   localparam int REPORT_LIMIT = 20;

   typedef struct packed {
      logic              kind;
      logic [DEST_W-1:0] dest;
      logic [COLOR_W-1:0] color;
      logic [ADDR_W-1:0] addr;
      logic              wide;
      logic              last;
   } dest_write_type;

   dest_write_type owed_writes[$];

   logic cfg_flip;
   logic cfg_mode;
   logic wide_latch;
   logic [BASE_W-1:0] base;
   int col;
   int row;

   initial begin
      mismatches = 0;
      writes_owed = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < REPORT_LIMIT)
         $display("tb: %s mismatch at %0t ns: got %h, expected %h", what, $time, got, want);
      mismatches++;
   endtask

   // Each 5-bit channel is widened by copying its top three bits below it.
   function automatic logic [COLOR_W-1:0] argb_from_rgb555(input logic [14:0] px);
      return {ALPHA_OPAQUE, px[14:10], px[14:12], px[9:5], px[9:7], px[4:0], px[4:2]};
   endfunction

   task automatic predict_writes(input logic act, input logic [OFFSET_W-1:0] off,
                                 input logic [PIXEL_W-1:0] raw);
      logic [14:0] px;
      logic [31:0] addr;
      int pitch;
      int drow;
      dest_write_type w;
      if (act == ACT_FRAME) begin
         // The latch looks at the raw offset, before the range clamp.
         if (off != '0 && off % WIDE_STRIDE == '0)
            wide_latch = 1'b1;
         base = (off > OFFSET_LIMIT) ? '0 : off[BASE_W-1:0];
         col = 0;
         row = 0;
         w.kind = KIND_FRAME;
         w.dest = '0;
         w.color = '0;
         w.addr = RAM_BASE + ADDR_W'(base);
         w.wide = wide_latch;
         w.last = 1'b1;
         owed_writes.push_back(w);
      end else begin
         px = raw[14:0];
         pitch = wide_latch ? WIDE_PITCH : NARROW_PITCH;
         drow = 2 * (cfg_flip ? SRC_HEIGHT - 1 - row : row);
         addr = 32'(RAM_BASE) + 32'(base) + 32'(row * pitch) + 32'(col * 2);
         w.kind = KIND_PIXEL;
         w.color = cfg_mode ? COLOR_W'(px) : argb_from_rgb555(px);
         w.addr = addr[ADDR_W-1:0];
         w.wide = wide_latch;
         w.dest = DEST_W'(drow * SRC_WIDTH + col);
         w.last = 1'b0;
         owed_writes.push_back(w);
         w.dest = DEST_W'((drow + 1) * SRC_WIDTH + col);
         w.last = 1'b1;
         owed_writes.push_back(w);
         col++;
         if (col >= SRC_WIDTH) begin
            col = 0;
            row++;
            if (row >= SRC_HEIGHT)
               row = 0;
         end
      end
   endtask

   always @(posedge clock) begin
      dest_write_type want;
      logic held;
      if (reset) begin
         cfg_flip = 1'b1;
         cfg_mode = 1'b0;
         wide_latch = 1'b0;
         base = '0;
         col = 0;
         row = 0;
         owed_writes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_FLIP)
                  cfg_flip = csr_pwdata[0];
               else
                  cfg_mode = csr_pwdata[0];
            end else begin
               held = (csr_paddr[2] == CSR_FLIP) ? cfg_flip : cfg_mode;
               if (csr_prdata !== CSR_DATA_W'(held))
                  report_mismatch("register read", csr_prdata, CSR_DATA_W'(held));
            end
         end
         if (req_valid && !req_stall)
            predict_writes(req_action, req_fb_offset, req_pixel);
         if (rsp_valid && !rsp_stall) begin
            if (owed_writes.size() == 0) begin
               report_mismatch("unrequested result", 32'(rsp_dest_index), '0);
            end else begin
               want = owed_writes.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
               if (rsp_dest_index !== want.dest)
                  report_mismatch("dest_index", 32'(rsp_dest_index), 32'(want.dest));
               if (rsp_color !== want.color)
                  report_mismatch("color", rsp_color, want.color);
               if (rsp_source_address !== want.addr)
                  report_mismatch("source_address", 32'(rsp_source_address),
                                  32'(want.addr));
               if (rsp_wide_pitch !== want.wide)
                  report_mismatch("wide_pitch", 32'(rsp_wide_pitch), 32'(want.wide));
               if (rsp_last !== want.last)
                  report_mismatch("last", 32'(rsp_last), 32'(want.last));
            end
         end
      end
      writes_owed = owed_writes.size();
   end

endmodule

// ===== bench/framebuffer_scanout_converter_test.sv =====
// Top of the scanout converter testbench: clock, reset, stimulus and verdict.
module framebuffer_scanout_converter_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fsc_pkg::*;

   localparam int SRC_WIDTH = 640;
   localparam int SRC_HEIGHT = 240;
   localparam logic [OFFSET_W-1:0] WIDE_STRIDE = 32'h0007_8000;
   localparam logic [CSR_ADDR_W-1:0] FLIP_ADDR = {CSR_FLIP, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR = {CSR_MODE, 2'b00};
   localparam int IDLE_PERCENT = 28;
   localparam int HOLD_CYCLES = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS = 6;
   localparam int PHASE_COUNT = 6;
   localparam int LATCH_PHASE = 3;
   localparam bit [PHASE_COUNT-1:0] FLIP_PLAN = 6'b101001;
   localparam bit [PHASE_COUNT-1:0] MODE_PLAN = 6'b011010;
   localparam int TIMEOUT_NS = 200_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_action = ACT_FRAME;
   logic [OFFSET_W-1:0]   req_fb_offset = '0;
   logic [PIXEL_W-1:0]    req_pixel = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_kind;
   logic [DEST_W-1:0]     rsp_dest_index;
   logic [COLOR_W-1:0]    rsp_color;
   logic [ADDR_W-1:0]     rsp_source_address;
   logic                  rsp_wide_pitch;
   logic                  rsp_last;

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatches;
   int writes_owed;
   int frames_sent = 0;
   int pixels_sent = 0;
   bit steady_run = 1'b0;
   bit hold_requested = 1'b0;

   framebuffer_scanout_converter #(
      .SRC_WIDTH(SRC_WIDTH),
      .SRC_HEIGHT(SRC_HEIGHT)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_fb_offset(req_fb_offset),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_dest_index(rsp_dest_index),
      .rsp_color(rsp_color),
      .rsp_source_address(rsp_source_address),
      .rsp_wide_pitch(rsp_wide_pitch),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   framebuffer_scanout_checker #(
      .SRC_WIDTH(SRC_WIDTH),
      .SRC_HEIGHT(SRC_HEIGHT)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_fb_offset(req_fb_offset),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_dest_index(rsp_dest_index),
      .rsp_color(rsp_color),
      .rsp_source_address(rsp_source_address),
      .rsp_wide_pitch(rsp_wide_pitch),
      .rsp_last(rsp_last),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .mismatches(mismatches),
      .writes_owed(writes_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random stalls, or a long hold-off when the stimulus asks for one.
   always begin
      @(negedge clock);
      if (hold_requested) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_requested = 1'b0;
      end else begin
         rsp_stall <= !steady_run && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   task automatic send_item(input logic act, input logic [OFFSET_W-1:0] off,
                            input logic [PIXEL_W-1:0] px);
      @(negedge clock);
      while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_fb_offset <= off;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      if (act == ACT_FRAME)
         frames_sent++;
      else
         pixels_sent++;
   endtask

   task automatic send_frame(input logic [OFFSET_W-1:0] off);
      send_item(ACT_FRAME, off, PIXEL_W'($urandom));
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] px);
      send_item(ACT_PIXEL, $urandom, px);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (writes_owed != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Before the latch phase, offsets that would set the wide pitch are nudged off by one.
   function automatic logic [OFFSET_W-1:0] pick_offset(input bit wide_ok);
      int roll;
      logic [OFFSET_W-1:0] off;
      roll = $urandom_range(99);
      if (roll < 25)
         off = $urandom;
      else if (roll < 60)
         off = $urandom_range(OFFSET_LIMIT, 0);
      else if (roll < 70)
         off = OFFSET_LIMIT + $urandom_range(1);
      else if (roll < 78)
         off = '0;
      else if (roll < 88)
         off = WIDE_STRIDE * $urandom_range(9, 1);
      else
         off = $urandom_range(32'h003F_FFFF);
      if (!wide_ok && off != '0 && off % WIDE_STRIDE == '0)
         off = off ^ 32'h1;
      return off;
   endfunction

   initial begin
      #TIMEOUT_NS;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int sent;
      int roll;
      int burst;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Reset values, then the field extremes with the narrow pitch still in force.
      csr_access(1'b0, FLIP_ADDR, '0);
      csr_access(1'b0, MODE_ADDR, '0);
      send_frame('0);
      send_pixel(16'h0000);
      send_pixel(16'h7FFF);
      send_pixel(16'hFFFF);
      send_pixel(16'h8000);
      send_pixel(16'h5555);
      send_pixel(16'h2AAA);
      send_frame(32'hFFFF_FFFF);
      send_pixel(16'h7C00);
      send_frame(OFFSET_LIMIT);
      send_pixel(16'h03E0);
      send_frame(OFFSET_LIMIT + 1);
      send_pixel(16'h001F);
      send_frame(32'h0012_3456);
      send_pixel(16'hD6B5);
      send_frame(WIDE_STRIDE + 1);
      send_pixel(16'h4210);
      wait_idle();

      // One source row plus a few pixels, so the column counter wraps into the next row.
      steady_run = 1'b1;
      send_frame(32'h0000_1000);
      repeat (SRC_WIDTH + 3) send_pixel(PIXEL_W'($urandom));
      steady_run = 1'b0;
      wait_idle();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         csr_access(1'b1, FLIP_ADDR, CSR_DATA_W'(FLIP_PLAN[phase]));
         csr_access(1'b1, MODE_ADDR, CSR_DATA_W'(MODE_PLAN[phase]));
         csr_access(1'b0, FLIP_ADDR, '0);
         csr_access(1'b0, MODE_ADDR, '0);
         if (phase == LATCH_PHASE) begin
            // A stride multiple above the limit sets the latch yet leaves the base at zero.
            send_frame(WIDE_STRIDE * 16);
            send_pixel(16'h7FFF);
            send_frame(WIDE_STRIDE * 6);
            send_pixel(16'h1234);
            send_pixel(16'hFEDC);
         end
         hold_requested = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_frame(pick_offset(phase >= LATCH_PHASE));
            roll = $urandom_range(99);
            if (roll < 15)
               burst = 0;
            else
               burst = $urandom_range(4, 1);
            repeat (burst) send_pixel(PIXEL_W'($urandom));
            sent += burst + 1;
         end
         wait_idle();
      end

      $display("tb: sent %0d frame starts and %0d pixels over %0d flip and format settings,",
               frames_sent, pixels_sent, PHASE_COUNT);
      $display("tb: with a run across a row boundary, the sticky wide pitch and result hold-offs");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
